[rtl/core/brlt_pkg.sv]
// Package for the byte-range lock table.
// Holds the operation, status and sequencer codes and the default sizes.
// No dependencies.
package brlt_pkg;

  localparam int TABLE_ENTRIES_DEF = 512;
  localparam int FILE_ID_BITS_DEF  = 16;
  localparam int OWNER_BITS_DEF    = 16;

  localparam int IN_FILE_W  = 16;
  localparam int IN_OWNER_W = 16;
  localparam int OP_W       = 3;
  localparam int ADDR_W     = 64;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY    = 3'd0,
    OP_SET      = 3'd1,
    OP_UNLOCK   = 3'd2,
    OP_REL_FILE = 3'd3,
    OP_REL_ALL  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BADF    = 2'd1,
    STS_BLOCK   = 2'd2,
    STS_NOSPACE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CARVE,
    S_MERGE,
    S_RELEASE
  } state_t;

endpackage

[rtl/core/brlt_cell.sv]
// One cell of the rotating lock ring: holds a single lock entry.
// Loads its neighbor's entry whenever the ring shifts. Uses brlt_pkg.
module brlt_cell #(
  parameter int FW = 16,
  parameter int OW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic                       d_valid,
  input  logic [FW-1:0]              d_file,
  input  logic [OW-1:0]              d_owner,
  input  logic                       d_wr,
  input  logic [brlt_pkg::ADDR_W-1:0] d_first,
  input  logic [brlt_pkg::ADDR_W-1:0] d_last,
  output logic                       q_valid,
  output logic [FW-1:0]              q_file,
  output logic [OW-1:0]              q_owner,
  output logic                       q_wr,
  output logic [brlt_pkg::ADDR_W-1:0] q_first,
  output logic [brlt_pkg::ADDR_W-1:0] q_last
);

  logic                        valid_r;
  logic [FW-1:0]               file_r;
  logic [OW-1:0]               owner_r;
  logic                        wr_r;
  logic [brlt_pkg::ADDR_W-1:0] first_r;
  logic [brlt_pkg::ADDR_W-1:0] last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      file_r  <= d_file;
      owner_r <= d_owner;
      wr_r    <= d_wr;
      first_r <= d_first;
      last_r  <= d_last;
    end
  end

  assign q_valid = valid_r;
  assign q_file  = file_r;
  assign q_owner = owner_r;
  assign q_wr    = wr_r;
  assign q_first = first_r;
  assign q_last  = last_r;

endmodule

[rtl/core/brlt_ctrl.sv]
// Sequencer and ring head for the byte-range lock table.
// Runs scan, carve, merge and release passes over the rotating ring. Uses brlt_pkg.
module brlt_ctrl #(
  parameter int TABLE_ENTRIES = brlt_pkg::TABLE_ENTRIES_DEF,
  parameter int FW            = 16,
  parameter int OW            = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [brlt_pkg::OP_W-1:0]      in_operation,
  input  logic [brlt_pkg::IN_FILE_W-1:0] in_file_id,
  input  logic [brlt_pkg::IN_OWNER_W-1:0] in_owner_id,
  input  logic                          in_lock_type,
  input  logic [brlt_pkg::ADDR_W-1:0]    in_range_start,
  input  logic [brlt_pkg::ADDR_W-1:0]    in_range_end,
  input  logic                          in_fd_writable,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_conflict_found,
  output logic                          out_conflict_type,
  output logic [brlt_pkg::ADDR_W-1:0]    out_conflict_start,
  output logic [brlt_pkg::ADDR_W-1:0]    out_conflict_length,
  output logic [brlt_pkg::IN_OWNER_W-1:0] out_conflict_owner,
  output logic                          out_wake_waiters,
  output logic                          shift_en,
  input  logic                          head_valid,
  input  logic [FW-1:0]                 head_file,
  input  logic [OW-1:0]                 head_owner,
  input  logic                          head_wr,
  input  logic [brlt_pkg::ADDR_W-1:0]    head_first,
  input  logic [brlt_pkg::ADDR_W-1:0]    head_last,
  output logic                          tail_valid,
  output logic [FW-1:0]                 tail_file,
  output logic [OW-1:0]                 tail_owner,
  output logic                          tail_wr,
  output logic [brlt_pkg::ADDR_W-1:0]    tail_first,
  output logic [brlt_pkg::ADDR_W-1:0]    tail_last
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int AW = brlt_pkg::ADDR_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  brlt_pkg::state_t  state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  brlt_pkg::op_t     op_r, op_nxt;
  logic [FW-1:0]     file_r, file_nxt;
  logic [OW-1:0]     owner_r, owner_nxt;
  logic              wr_r, wr_nxt;
  logic [AW-1:0]     s_r, s_nxt, e_r, e_nxt;

  logic              cf_found_r, cf_found_nxt, cf_w_r, cf_w_nxt;
  logic [AW-1:0]     cf_first_r, cf_first_nxt, cf_last_r, cf_last_nxt;
  logic [OW-1:0]     cf_owner_r, cf_owner_nxt;
  logic              free_any_r, free_any_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic              split_r, split_nxt, split_w_r, split_w_nxt;
  logic [AW-1:0]     split_last_r, split_last_nxt;
  logic              r_found_r, r_found_nxt;
  logic [IW-1:0]     r_idx_r, r_idx_nxt;
  logic              l_found_r, l_found_nxt;
  logic [IW-1:0]     l_idx_r, l_idx_nxt;
  logic [AW-1:0]     l_first_r, l_first_nxt;
  logic              rr_found_r, rr_found_nxt;
  logic [IW-1:0]     rr_idx_r, rr_idx_nxt;
  logic [AW-1:0]     rr_last_r, rr_last_nxt;
  logic              drop_r, drop_nxt;

  logic              ov_r, ov_nxt;
  brlt_pkg::status_t ost_r, ost_nxt;
  logic              ocf_r, ocf_nxt, ocw_r, ocw_nxt, owake_r, owake_nxt;
  logic [AW-1:0]     ocs_r, ocs_nxt, ocl_r, ocl_nxt;
  logic [brlt_pkg::IN_OWNER_W-1:0] oco_r, oco_nxt;

  logic              mine, meet, at_end;
  logic [IW-1:0]     m_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brlt_pkg::S_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    file_r       <= file_nxt;
    owner_r      <= owner_nxt;
    wr_r         <= wr_nxt;
    s_r          <= s_nxt;
    e_r          <= e_nxt;
    cf_found_r   <= cf_found_nxt;
    cf_w_r       <= cf_w_nxt;
    cf_first_r   <= cf_first_nxt;
    cf_last_r    <= cf_last_nxt;
    cf_owner_r   <= cf_owner_nxt;
    free_any_r   <= free_any_nxt;
    free_idx_r   <= free_idx_nxt;
    split_r      <= split_nxt;
    split_w_r    <= split_w_nxt;
    split_last_r <= split_last_nxt;
    r_found_r    <= r_found_nxt;
    r_idx_r      <= r_idx_nxt;
    l_found_r    <= l_found_nxt;
    l_idx_r      <= l_idx_nxt;
    l_first_r    <= l_first_nxt;
    rr_found_r   <= rr_found_nxt;
    rr_idx_r     <= rr_idx_nxt;
    rr_last_r    <= rr_last_nxt;
    drop_r       <= drop_nxt;
    ost_r        <= ost_nxt;
    ocf_r        <= ocf_nxt;
    ocw_r        <= ocw_nxt;
    ocs_r        <= ocs_nxt;
    ocl_r        <= ocl_nxt;
    oco_r        <= oco_nxt;
    owake_r      <= owake_nxt;
  end

  always_comb begin
    m_idx = r_idx_r;
    if (l_found_r && (l_idx_r < m_idx)) begin
      m_idx = l_idx_r;
    end
    if (rr_found_r && (rr_idx_r < m_idx)) begin
      m_idx = rr_idx_r;
    end
  end

  assign mine   = head_valid && (head_file == file_r) && (head_owner == owner_r);
  assign meet   = (head_first <= e_r) && (s_r <= head_last);
  assign at_end = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    file_nxt       = file_r;
    owner_nxt      = owner_r;
    wr_nxt         = wr_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    cf_found_nxt   = cf_found_r;
    cf_w_nxt       = cf_w_r;
    cf_first_nxt   = cf_first_r;
    cf_last_nxt    = cf_last_r;
    cf_owner_nxt   = cf_owner_r;
    free_any_nxt   = free_any_r;
    free_idx_nxt   = free_idx_r;
    split_nxt      = split_r;
    split_w_nxt    = split_w_r;
    split_last_nxt = split_last_r;
    r_found_nxt    = r_found_r;
    r_idx_nxt      = r_idx_r;
    l_found_nxt    = l_found_r;
    l_idx_nxt      = l_idx_r;
    l_first_nxt    = l_first_r;
    rr_found_nxt   = rr_found_r;
    rr_idx_nxt     = rr_idx_r;
    rr_last_nxt    = rr_last_r;
    drop_nxt       = drop_r;
    ov_nxt         = 1'b0;
    ost_nxt        = ost_r;
    ocf_nxt        = ocf_r;
    ocw_nxt        = ocw_r;
    ocs_nxt        = ocs_r;
    ocl_nxt        = ocl_r;
    oco_nxt        = oco_r;
    owake_nxt      = owake_r;
    shift_en       = 1'b0;
    tail_valid     = head_valid;
    tail_file      = head_file;
    tail_owner     = head_owner;
    tail_wr        = head_wr;
    tail_first     = head_first;
    tail_last      = head_last;

    case (state_r)
      brlt_pkg::S_IDLE: begin
        if (start) begin
          op_nxt       = brlt_pkg::op_t'(in_operation);
          file_nxt     = in_file_id[FW-1:0];
          owner_nxt    = in_owner_id[OW-1:0];
          wr_nxt       = in_lock_type;
          s_nxt        = in_range_start;
          e_nxt        = in_range_end;
          idx_nxt      = '0;
          cf_found_nxt = 1'b0;
          free_any_nxt = 1'b0;
          split_nxt    = 1'b0;
          r_found_nxt  = 1'b0;
          l_found_nxt  = 1'b0;
          rr_found_nxt = 1'b0;
          drop_nxt     = 1'b0;
          ost_nxt      = brlt_pkg::STS_OK;
          ocf_nxt      = 1'b0;
          ocw_nxt      = 1'b0;
          ocs_nxt      = '0;
          ocl_nxt      = '0;
          oco_nxt      = '0;
          owake_nxt    = 1'b0;
          case (brlt_pkg::op_t'(in_operation))
            brlt_pkg::OP_QUERY, brlt_pkg::OP_UNLOCK: begin
              if (in_range_start > in_range_end) begin
                ov_nxt = 1'b1;
              end else begin
                state_nxt = brlt_pkg::S_SCAN;
              end
            end
            brlt_pkg::OP_SET: begin
              if (in_lock_type && !in_fd_writable) begin
                ost_nxt = brlt_pkg::STS_BADF;
                ov_nxt  = 1'b1;
              end else if (in_range_start > in_range_end) begin
                ov_nxt = 1'b1;
              end else begin
                state_nxt = brlt_pkg::S_SCAN;
              end
            end
            brlt_pkg::OP_REL_FILE, brlt_pkg::OP_REL_ALL: begin
              state_nxt = brlt_pkg::S_RELEASE;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      brlt_pkg::S_SCAN: begin
        shift_en = 1'b1;
        idx_nxt  = at_end ? '0 : idx_r + 1'b1;
        if (!cf_found_nxt && head_valid && (head_file == file_r) &&
            (head_owner != owner_r) && meet && (head_wr || wr_r)) begin
          cf_found_nxt = 1'b1;
          cf_w_nxt     = head_wr;
          cf_first_nxt = head_first;
          cf_last_nxt  = head_last;
          cf_owner_nxt = head_owner;
        end
        if (!head_valid && !free_any_r) begin
          free_any_nxt = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (mine && (head_first < s_r) && (head_last > e_r)) begin
          split_nxt      = 1'b1;
          split_w_nxt    = head_wr;
          split_last_nxt = head_last;
        end
        if (at_end) begin
          state_nxt = brlt_pkg::S_IDLE;
          ov_nxt    = 1'b1;
          case (op_r)
            brlt_pkg::OP_QUERY: begin
              if (cf_found_nxt) begin
                ocf_nxt = 1'b1;
                ocw_nxt = cf_w_nxt;
                ocs_nxt = cf_first_nxt;
                ocl_nxt = (cf_last_nxt == brlt_pkg::ADDR_MAX) ? '0 :
                          cf_last_nxt - cf_first_nxt + 1'b1;
                oco_nxt = brlt_pkg::IN_OWNER_W'(cf_owner_nxt);
              end
            end
            brlt_pkg::OP_SET: begin
              if (cf_found_nxt) begin
                ost_nxt = brlt_pkg::STS_BLOCK;
              end else if (!free_any_nxt) begin
                ost_nxt = brlt_pkg::STS_NOSPACE;
              end else begin
                owake_nxt = 1'b1;
                ov_nxt    = 1'b0;
                state_nxt = brlt_pkg::S_CARVE;
              end
            end
            default: begin
              owake_nxt = 1'b1;
              if (split_nxt && !free_any_nxt) begin
                ost_nxt = brlt_pkg::STS_NOSPACE;
              end else begin
                ov_nxt    = 1'b0;
                state_nxt = brlt_pkg::S_CARVE;
              end
            end
          endcase
        end
      end

      brlt_pkg::S_CARVE: begin
        shift_en = 1'b1;
        idx_nxt  = at_end ? '0 : idx_r + 1'b1;
        if (split_r && (idx_r == free_idx_r)) begin
          tail_valid = 1'b1;
          tail_file  = file_r;
          tail_owner = owner_r;
          tail_wr    = split_w_r;
          tail_first = e_r + 1'b1;
          tail_last  = split_last_r;
        end else if (mine && meet) begin
          if ((head_first >= s_r) && (head_last <= e_r)) begin
            tail_valid = 1'b0;
          end else if (head_first < s_r) begin
            tail_last = s_r - 1'b1;
          end else begin
            tail_first = e_r + 1'b1;
          end
        end
        if (!tail_valid && !r_found_r) begin
          r_found_nxt = 1'b1;
          r_idx_nxt   = idx_r;
        end
        if (tail_valid && (tail_file == file_r) && (tail_owner == owner_r) &&
            (tail_wr == wr_r)) begin
          if ((s_r != '0) && (tail_last == s_r - 1'b1)) begin
            l_found_nxt = 1'b1;
            l_idx_nxt   = idx_r;
            l_first_nxt = tail_first;
          end
          if ((e_r != brlt_pkg::ADDR_MAX) && (tail_first == e_r + 1'b1)) begin
            rr_found_nxt = 1'b1;
            rr_idx_nxt   = idx_r;
            rr_last_nxt  = tail_last;
          end
        end
        if (at_end) begin
          if ((op_r == brlt_pkg::OP_SET) && r_found_nxt) begin
            state_nxt = brlt_pkg::S_MERGE;
          end else begin
            state_nxt = brlt_pkg::S_IDLE;
            ov_nxt    = 1'b1;
            if (op_r == brlt_pkg::OP_SET) begin
              ost_nxt = brlt_pkg::STS_NOSPACE;
            end
          end
        end
      end

      brlt_pkg::S_MERGE: begin
        shift_en = 1'b1;
        idx_nxt  = at_end ? '0 : idx_r + 1'b1;
        if (idx_r == m_idx) begin
          tail_valid = 1'b1;
          tail_file  = file_r;
          tail_owner = owner_r;
          tail_wr    = wr_r;
          tail_first = l_found_r ? l_first_r : s_r;
          tail_last  = rr_found_r ? rr_last_r : e_r;
        end else if ((l_found_r && (idx_r == l_idx_r)) ||
                     (rr_found_r && (idx_r == rr_idx_r))) begin
          tail_valid = 1'b0;
        end
        if (at_end) begin
          state_nxt = brlt_pkg::S_IDLE;
          ov_nxt    = 1'b1;
        end
      end

      brlt_pkg::S_RELEASE: begin
        shift_en = 1'b1;
        idx_nxt  = at_end ? '0 : idx_r + 1'b1;
        if (head_valid && (head_owner == owner_r) &&
            ((op_r == brlt_pkg::OP_REL_ALL) || (head_file == file_r))) begin
          tail_valid = 1'b0;
          drop_nxt   = 1'b1;
        end
        if (at_end) begin
          state_nxt = brlt_pkg::S_IDLE;
          ov_nxt    = 1'b1;
          owake_nxt = drop_nxt;
        end
      end

      default: begin
        state_nxt = brlt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy                = (state_r != brlt_pkg::S_IDLE);
  assign out_valid           = ov_r;
  assign out_status          = ost_r;
  assign out_conflict_found  = ocf_r;
  assign out_conflict_type   = ocw_r;
  assign out_conflict_start  = ocs_r;
  assign out_conflict_length = ocl_r;
  assign out_conflict_owner  = oco_r;
  assign out_wake_waiters    = owake_r;

endmodule

[rtl/core/byte_range_lock_table.sv]
// Top level of the byte-range lock table: a rotating ring of lock cells and its sequencer.
// Depends on brlt_pkg, brlt_cell and brlt_ctrl.
//
// A command word is taken at a clock edge where start is high and busy is low.
// Exactly one result word follows, shown for one cycle with out_valid high;
// the receiver cannot stall it and must take it in that cycle.
// The table is a ring of TABLE_ENTRIES cells that rotates one entry per cycle
// while a pass runs; a full pass turns the ring once around and leaves every
// entry back in its own cell.
// Passes run per command:
//   bad descriptor, empty range or unknown code: result with no pass;
//   query: a scan pass; release: a release pass;
//   unlock: scan, then carve (scan only if it fails for lack of room);
//   set: scan, carve, then insert and merge (ending early on a block or lack of room).
// One command is handled at a time; busy stays high until its result shows,
// and a new start may be given in the cycle the result is shown.
// Reset clears every cell's valid bit at once, so the table is empty and
// ready right after reset; no clearing pass is needed.
module byte_range_lock_table #(
  parameter int TABLE_ENTRIES = brlt_pkg::TABLE_ENTRIES_DEF,
  parameter int FILE_ID_BITS  = brlt_pkg::FILE_ID_BITS_DEF,
  parameter int OWNER_BITS    = brlt_pkg::OWNER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [brlt_pkg::OP_W-1:0]      in_operation,
  input  logic [brlt_pkg::IN_FILE_W-1:0] in_file_id,
  input  logic [brlt_pkg::IN_OWNER_W-1:0] in_owner_id,
  input  logic                          in_lock_type,
  input  logic [brlt_pkg::ADDR_W-1:0]    in_range_start,
  input  logic [brlt_pkg::ADDR_W-1:0]    in_range_end,
  input  logic                          in_fd_writable,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_conflict_found,
  output logic                          out_conflict_type,
  output logic [brlt_pkg::ADDR_W-1:0]    out_conflict_start,
  output logic [brlt_pkg::ADDR_W-1:0]    out_conflict_length,
  output logic [brlt_pkg::IN_OWNER_W-1:0] out_conflict_owner,
  output logic                          out_wake_waiters
);

  localparam int FW = (FILE_ID_BITS < brlt_pkg::IN_FILE_W) ? FILE_ID_BITS :
                      brlt_pkg::IN_FILE_W;
  localparam int OW = (OWNER_BITS < brlt_pkg::IN_OWNER_W) ? OWNER_BITS :
                      brlt_pkg::IN_OWNER_W;
  localparam int AW = brlt_pkg::ADDR_W;

  logic          shift_en;
  logic          cv [TABLE_ENTRIES];
  logic [FW-1:0] cf [TABLE_ENTRIES];
  logic [OW-1:0] co [TABLE_ENTRIES];
  logic          cw [TABLE_ENTRIES];
  logic [AW-1:0] cs [TABLE_ENTRIES];
  logic [AW-1:0] cl [TABLE_ENTRIES];

  logic          tv;
  logic [FW-1:0] tf;
  logic [OW-1:0] to;
  logic          tw;
  logic [AW-1:0] ts;
  logic [AW-1:0] tl;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      brlt_cell #(.FW(FW), .OW(OW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_valid  (tv),
        .d_file   (tf),
        .d_owner  (to),
        .d_wr     (tw),
        .d_first  (ts),
        .d_last   (tl),
        .q_valid  (cv[k]),
        .q_file   (cf[k]),
        .q_owner  (co[k]),
        .q_wr     (cw[k]),
        .q_first  (cs[k]),
        .q_last   (cl[k])
      );
    end else begin : g_body
      brlt_cell #(.FW(FW), .OW(OW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_valid  (cv[k+1]),
        .d_file   (cf[k+1]),
        .d_owner  (co[k+1]),
        .d_wr     (cw[k+1]),
        .d_first  (cs[k+1]),
        .d_last   (cl[k+1]),
        .q_valid  (cv[k]),
        .q_file   (cf[k]),
        .q_owner  (co[k]),
        .q_wr     (cw[k]),
        .q_first  (cs[k]),
        .q_last   (cl[k])
      );
    end
  end

  brlt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FW            (FW),
    .OW            (OW)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_file_id          (in_file_id),
    .in_owner_id         (in_owner_id),
    .in_lock_type        (in_lock_type),
    .in_range_start      (in_range_start),
    .in_range_end        (in_range_end),
    .in_fd_writable      (in_fd_writable),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_conflict_found  (out_conflict_found),
    .out_conflict_type   (out_conflict_type),
    .out_conflict_start  (out_conflict_start),
    .out_conflict_length (out_conflict_length),
    .out_conflict_owner  (out_conflict_owner),
    .out_wake_waiters    (out_wake_waiters),
    .shift_en            (shift_en),
    .head_valid          (cv[0]),
    .head_file           (cf[0]),
    .head_owner          (co[0]),
    .head_wr             (cw[0]),
    .head_first          (cs[0]),
    .head_last           (cl[0]),
    .tail_valid          (tv),
    .tail_file           (tf),
    .tail_owner          (to),
    .tail_wr             (tw),
    .tail_first          (ts),
    .tail_last           (tl)
  );

endmodule

[rtl/core/brlt_checker.sv]
// Port-level checks for the byte-range lock table, bound to the top level.
// Depends on brlt_pkg and byte_range_lock_table.
module brlt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic       out_conflict_found,
  input logic       out_wake_waiters
);

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_start_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word neither started nor answered");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_conflict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_conflict_found) |-> (out_status == brlt_pkg::STS_OK))
    else $error("conflict reported with error status");

  a_badf_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == brlt_pkg::STS_BADF)) |->
      (!out_wake_waiters && !out_conflict_found))
    else $error("bad descriptor result raised other flags");

endmodule

bind byte_range_lock_table brlt_checker u_brlt_checker (.*);
